>>> src/midi_sostenuto_filter_assert.svh
// Assertion macros for the sostenuto filter checker.
`ifndef MIDI_SOSTENUTO_FILTER_ASSERT_SVH
`define MIDI_SOSTENUTO_FILTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MSF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msf check failed");

// Next-cycle implication, disabled during reset.
`define MSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msf check failed");

`endif

>>> src/msf_pkg.sv
package msf_pkg;

  // map size and bank layout
  localparam int NOTE_COUNT = 128;
  localparam int BANK_BITS  = 64;

  // message types (high nibble of the status byte)
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CC       = 4'hB;

  localparam logic [6:0] CC_ALL_NOTES_OFF = 7'd123;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PEDAL_CC        = 3'd0,
    CFG_LOW_NOTE        = 3'd1,
    CFG_HIGH_NOTE       = 3'd2,
    CFG_MIDI_CHANNEL    = 3'd3,
    CFG_PRESS_LEVEL     = 3'd4
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  // configuration reset values
  localparam logic [6:0] RST_PEDAL_CC        = 7'd66;
  localparam logic [6:0] RST_LOW_NOTE        = 7'd0;
  localparam logic [6:0] RST_HIGH_NOTE       = 7'd127;
  localparam logic [3:0] RST_MIDI_CHANNEL    = 4'd0;
  localparam logic [6:0] RST_PRESS_LEVEL     = 7'd64;

  // result slots of one run, in emission order
  localparam int SLOT_MASK0    = 0;
  localparam int SLOT_MASK1    = 1;
  localparam int SLOT_MSG      = 2;
  localparam int SLOT_RESTRIKE = 3;
  localparam int SLOT_COUNT    = 4;

endpackage

>>> src/msf_in_if.sv
interface msf_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  status_byte;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [15:0] event_time;

  modport source (output valid, status_byte, first_data, second_data, event_time,
                  input ready);
  modport sink (input valid, status_byte, first_data, second_data, event_time,
                output ready);
endinterface

>>> src/msf_out_if.sv
interface msf_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  out_status;
  logic [6:0]  out_first;
  logic [6:0]  out_second;
  logic [63:0] release_mask;
  logic        mask_bank;
  logic [15:0] out_time;
  logic        last_of_run;

  modport source (output valid, result_kind, out_status, out_first, out_second,
                         release_mask, mask_bank, out_time, last_of_run,
                  input ready);
  modport sink (input valid, result_kind, out_status, out_first, out_second,
                      release_mask, mask_bank, out_time, last_of_run,
                output ready);
endinterface

>>> src/msf_cfg_if.sv
interface msf_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/midi_sostenuto_filter.sv
// A message is taken into the input register; its results are then loaded into the
// result register once that register is free, and are offered from there.
// Throughput: one message per cycle when each causes at most one result and res.ready is
// high; otherwise a message holds the result register until all of its results transfer.
// Reset (rst, synchronous, active high): note maps and pedal clear,
// configuration returns to defaults, pipeline empties.
module midi_sostenuto_filter (
  input  logic       clk,
  input  logic       rst,
  msf_in_if.sink     msg,
  msf_out_if.source  res,
  msf_cfg_if.sink    cfg
);
  import msf_pkg::*;

  // configuration registers
  logic [6:0] pedal_cc;
  logic [6:0] low_note;
  logic [6:0] high_note;
  logic [3:0] midi_channel;
  logic [6:0] press_level;

  // note state
  logic [NOTE_COUNT-1:0] held_map;
  logic [NOTE_COUNT-1:0] sustained_map;
  logic                  pedal_down;

  // input register
  logic        s1_valid;
  logic [7:0]  s1_status;
  logic [6:0]  s1_d1;
  logic [6:0]  s1_d2;
  logic [15:0] s1_time;

  // result register: one run of up to four results
  logic [SLOT_COUNT-1:0] pending;
  logic [BANK_BITS-1:0]  run_freed0;
  logic [BANK_BITS-1:0]  run_freed1;
  logic [7:0]            run_status;
  logic [6:0]            run_d1;
  logic [6:0]            run_d2;
  logic [15:0]           run_time;
  logic [3:0]            run_chan;

  // config writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_cc        <= RST_PEDAL_CC;
      low_note        <= RST_LOW_NOTE;
      high_note       <= RST_HIGH_NOTE;
      midi_channel    <= RST_MIDI_CHANNEL;
      press_level     <= RST_PRESS_LEVEL;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PEDAL_CC:        pedal_cc        <= cfg.data;
        CFG_LOW_NOTE:        low_note        <= cfg.data;
        CFG_HIGH_NOTE:       high_note       <= cfg.data;
        CFG_MIDI_CHANNEL:    midi_channel    <= cfg.data[3:0];
        CFG_PRESS_LEVEL:     press_level     <= cfg.data;
        default: ;
      endcase
    end
  end

  // run drain control
  logic [SLOT_COUNT-1:0] cur;
  logic [SLOT_COUNT-1:0] pending_rest;
  logic                  out_xfer;
  logic                  run_free;
  logic                  s1_adv;

  assign cur          = pending & (~pending + SLOT_COUNT'(1));
  assign pending_rest = pending & ~cur;
  assign out_xfer     = res.valid && res.ready;
  assign run_free     = (pending == '0) || (out_xfer && (pending_rest == '0));
  assign s1_adv       = s1_valid && run_free;
  assign msg.ready    = !s1_valid || run_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (msg.ready) begin
      s1_valid <= msg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) begin
      s1_status <= msg.status_byte;
      s1_d1     <= msg.first_data;
      s1_d2     <= msg.second_data;
      s1_time   <= msg.event_time;
    end
  end

  // message decode and pedal logic
  logic [3:0]            m_type;
  logic                  on_ch;
  logic                  is_note_on;
  logic                  is_note_off;
  logic                  is_cc;
  logic                  all_off;
  logic                  in_range;
  logic                  sus_bit;
  logic                  restrike;
  logic                  drop;
  logic                  pedal_hit;
  logic                  pedal_press;
  logic                  pedal_lift;
  logic                  pd_eff;
  logic [NOTE_COUNT-1:0] freed;
  logic [NOTE_COUNT-1:0] held_next;
  logic [NOTE_COUNT-1:0] sustained_next;
  logic                  pedal_down_next;

  always_comb begin
    m_type      = s1_status[7:4];
    on_ch       = (s1_status[3:0] == midi_channel);
    is_cc       = (m_type == TYPE_CC);
    is_note_on  = (m_type == TYPE_NOTE_ON) && (s1_d2 != 7'd0);
    is_note_off = (m_type == TYPE_NOTE_OFF) || ((m_type == TYPE_NOTE_ON) && (s1_d2 == 7'd0));
    all_off     = on_ch && is_cc && (s1_d1 == CC_ALL_NOTES_OFF);
    in_range    = (s1_d1 >= low_note) && (s1_d1 <= high_note);
    sus_bit     = sustained_map[s1_d1];
    pd_eff      = pedal_down && !all_off;

    restrike    = on_ch && is_note_on && in_range && pedal_down && sus_bit;
    pedal_hit   = on_ch && is_cc && (s1_d1 == pedal_cc);
    pedal_press = pedal_hit && (s1_d2 >= press_level) && !pd_eff;
    pedal_lift  = pedal_hit && (s1_d2 < press_level) && pd_eff;
    drop        = (on_ch && is_note_off && sus_bit) || pedal_hit;

    freed = '0;
    if (all_off) begin
      freed = sustained_map;
    end else if (pedal_lift) begin
      freed = sustained_map & ~held_map;
    end

    held_next = held_map;
    if (on_ch && is_note_on && in_range) begin
      held_next[s1_d1] = 1'b1;
    end else if (on_ch && is_note_off) begin
      held_next[s1_d1] = 1'b0;
    end

    sustained_next  = sustained_map;
    pedal_down_next = pd_eff;
    if (pedal_press) begin
      sustained_next  = held_map;
      pedal_down_next = 1'b1;
    end else if (all_off || pedal_lift) begin
      sustained_next  = '0;
      pedal_down_next = 1'b0;
    end
  end

  // state update and result register load
  always_ff @(posedge clk) begin
    if (rst) begin
      held_map      <= '0;
      sustained_map <= '0;
      pedal_down    <= 1'b0;
      pending       <= '0;
    end else if (s1_adv) begin
      held_map                <= held_next;
      sustained_map           <= sustained_next;
      pedal_down              <= pedal_down_next;
      pending[SLOT_MASK0]     <= (freed[BANK_BITS-1:0] != '0);
      pending[SLOT_MASK1]     <= (freed[NOTE_COUNT-1:BANK_BITS] != '0);
      pending[SLOT_MSG]       <= !drop;
      pending[SLOT_RESTRIKE]  <= restrike;
    end else if (out_xfer) begin
      pending <= pending_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      run_freed0 <= freed[BANK_BITS-1:0];
      run_freed1 <= freed[NOTE_COUNT-1:BANK_BITS];
      run_status <= restrike ? {TYPE_NOTE_OFF, midi_channel} : s1_status;
      run_d1     <= s1_d1;
      run_d2     <= s1_d2;
      run_time   <= s1_time;
      run_chan   <= midi_channel;
    end
  end

  // output select: lowest pending slot goes first
  always_comb begin
    res.valid        = (pending != '0);
    res.result_kind  = cur[SLOT_MASK0] || cur[SLOT_MASK1];
    res.mask_bank    = cur[SLOT_MASK1];
    res.out_time     = run_time;
    res.last_of_run  = (pending_rest == '0);
    res.out_first    = (cur[SLOT_MSG] || cur[SLOT_RESTRIKE]) ? run_d1 : 7'd0;
    res.out_second   = (cur[SLOT_MSG] || cur[SLOT_RESTRIKE]) ? run_d2 : 7'd0;
    if (cur[SLOT_MSG]) begin
      res.out_status = run_status;
    end else if (cur[SLOT_RESTRIKE]) begin
      res.out_status = {TYPE_NOTE_ON, run_chan};
    end else begin
      res.out_status = {TYPE_NOTE_OFF, run_chan};
    end
    if (cur[SLOT_MASK0]) begin
      res.release_mask = run_freed0;
    end else if (cur[SLOT_MASK1]) begin
      res.release_mask = run_freed1;
    end else begin
      res.release_mask = '0;
    end
  end

endmodule

>>> src/msf_checker.sv
`include "midi_sostenuto_filter_assert.svh"

module msf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        result_kind,
  input logic [7:0]  out_status,
  input logic [63:0] release_mask,
  input logic        mask_bank,
  input logic        last_of_run
);
  import msf_pkg::*;

  logic out_xfer;
  assign out_xfer = out_valid && out_ready;

  // a stalled result stays offered
  `MSF_ASSERT_NEXT(a_valid_holds, clk, rst, out_valid && !out_ready, out_valid)

  // a run that is not finished keeps delivering the next cycle
  `MSF_ASSERT_NEXT(a_run_continues, clk, rst, out_xfer && !last_of_run, out_valid)

  // note-off masks carry a note-off status and at least one note
  `MSF_ASSERT_NOW(a_mask_shape, clk, rst, out_valid && result_kind,
    (out_status[7:4] == TYPE_NOTE_OFF) && (release_mask != 64'd0))

  // single messages carry no mask
  `MSF_ASSERT_NOW(a_msg_no_mask, clk, rst, out_valid && !result_kind,
    (release_mask == 64'd0) && !mask_bank)

endmodule

bind midi_sostenuto_filter msf_checker u_msf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .result_kind  (res.result_kind),
  .out_status   (res.out_status),
  .release_mask (res.release_mask),
  .mask_bank    (res.mask_bank),
  .last_of_run  (res.last_of_run)
);
